// File: rtl/core/smb_pkg.sv
// Types, constants and phase decode functions shared by the SMBus master.
// Depends on nothing; smb_engine and smbus_master_with_pec import it.
package smb_pkg;

   typedef enum logic [1:0] {
      MODE_START = 2'd0,
      MODE_WRITE = 2'd1,
      MODE_READ  = 2'd2,
      MODE_STOP  = 2'd3
   } smb_mode_type;

   localparam logic CSR_HOLD_LONG  = 1'b0;
   localparam logic CSR_HOLD_SHORT = 1'b1;

   localparam int unsigned CSR_WIDTH = 16;

   localparam logic [7:0] CRC_POLY = 8'h07;
   localparam logic [7:0] CRC_TOP  = 8'h80;

   localparam logic [4:0] WR_BIT_PHASES  = 5'd24;
   localparam logic [4:0] WR_ACK_RELEASE = 5'd24;
   localparam logic [4:0] WR_ACK_SAMPLE  = 5'd25;
   localparam logic [4:0] RD_BIT_PHASES  = 5'd16;
   localparam logic [4:0] RD_ACK_LOW     = 5'd16;
   localparam logic [4:0] RD_ACK_DRIVE   = 5'd17;
   localparam logic [4:0] RD_ACK_HIGH    = 5'd18;

   typedef struct packed {
      logic         cmd_valid;
      logic [1:0]   mode;
      logic [7:0]   write_data;
      logic         send_nack;
      logic         sda_in;
   } smb_cmd_type;

   typedef struct packed {
      logic         scl_out;
      logic         sda_out;
      logic         busy_res;
      logic         done_res;
      logic         nack_seen;
      logic [7:0]   read_data;
      logic [7:0]   pec;
   } smb_result_type;

   typedef struct packed {
      logic scl;
      logic sda;
      logic lng;
   } smb_drive_type;

   function automatic logic [7:0] crc_add(logic [7:0] crc, logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 8'h00) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

   function automatic logic [4:0] phase_total(smb_mode_type m);
      logic [4:0] t;
      unique case (m)
         MODE_START: t = 5'd4;
         MODE_WRITE: t = 5'd27;
         MODE_READ:  t = 5'd20;
         MODE_STOP:  t = 5'd3;
      endcase
      return t;
   endfunction

   function automatic logic [1:0] wr_sub(logic [4:0] p);
      logic [1:0] s;
      case (p) inside
         5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21: s = 2'd0;
         5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22: s = 2'd1;
         default: s = 2'd2;
      endcase
      return s;
   endfunction

   function automatic logic [2:0] wr_bit(logic [4:0] p);
      logic [2:0] b;
      case (p) inside
         [5'd0:5'd2]:   b = 3'd7;
         [5'd3:5'd5]:   b = 3'd6;
         [5'd6:5'd8]:   b = 3'd5;
         [5'd9:5'd11]:  b = 3'd4;
         [5'd12:5'd14]: b = 3'd3;
         [5'd15:5'd17]: b = 3'd2;
         [5'd18:5'd20]: b = 3'd1;
         default:       b = 3'd0;
      endcase
      return b;
   endfunction

   function automatic smb_drive_type phase_drive(smb_mode_type m, logic [4:0] p,
                                                 logic [7:0] sb, logic nc,
                                                 logic scl, logic sda);
      smb_drive_type d;
      d.scl = scl;
      d.sda = sda;
      d.lng = 1'b1;
      unique case (m)
         MODE_START: begin
            case (p)
               5'd0:    d.sda = 1'b1;
               5'd1:    d.scl = 1'b1;
               5'd2:    d.sda = 1'b0;
               default: d.scl = 1'b0;
            endcase
         end
         MODE_WRITE: begin
            if (p < WR_BIT_PHASES) begin
               case (wr_sub(p))
                  2'd0:    d.scl = 1'b0;
                  2'd1:    d.sda = sb[wr_bit(p)];
                  default: d.scl = 1'b1;
               endcase
            end else begin
               d.lng = 1'b0;
               if (p == WR_ACK_RELEASE) begin
                  d.scl = 1'b0;
                  d.sda = 1'b1;
               end else if (p == WR_ACK_SAMPLE) begin
                  d.scl = 1'b1;
               end else begin
                  d.scl = 1'b0;
               end
            end
         end
         MODE_READ: begin
            if (p < RD_BIT_PHASES) begin
               d.lng = 1'b0;
               if (!p[0]) begin
                  d.scl = 1'b0;
                  d.sda = 1'b1;
               end else begin
                  d.scl = 1'b1;
               end
            end else if (p == RD_ACK_LOW) begin
               d.scl = 1'b0;
            end else if (p == RD_ACK_DRIVE) begin
               d.sda = nc;
            end else if (p == RD_ACK_HIGH) begin
               d.scl = 1'b1;
            end else begin
               d.scl = 1'b0;
            end
         end
         MODE_STOP: begin
            case (p)
               5'd0:    d.sda = 1'b0;
               5'd1:    d.scl = 1'b1;
               default: d.sda = 1'b1;
            endcase
         end
      endcase
      return d;
   endfunction

endpackage

// File: rtl/core/smb_req_if.sv
// Command channel: one beat per bus tick, valid/ready handshake.
// Depends on nothing.
interface smb_req_if;
   logic         valid;
   logic         ready;
   logic         cmd_valid;
   logic [1:0]   mode;
   logic [7:0]   write_data;
   logic         send_nack;
   logic         sda_in;

   modport source (output valid, cmd_valid, mode, write_data, send_nack, sda_in,
                   input ready);
   modport sink   (input valid, cmd_valid, mode, write_data, send_nack, sda_in,
                   output ready);
endinterface

// File: rtl/core/smb_rsp_if.sv
// Result channel: one beat per accepted tick, valid/ready handshake.
// Depends on nothing.
interface smb_rsp_if;
   logic         valid;
   logic         ready;
   logic         scl_out;
   logic         sda_out;
   logic         busy_res;
   logic         done_res;
   logic         nack_seen;
   logic [7:0]   read_data;
   logic [7:0]   pec;

   modport source (output valid, scl_out, sda_out, busy_res, done_res, nack_seen,
                   read_data, pec, input ready);
   modport sink   (input valid, scl_out, sda_out, busy_res, done_res, nack_seen,
                   read_data, pec, output ready);
endinterface

// File: rtl/core/smb_engine.sv
// Bus phase engine: command decode, phase counter, hold timer, shift byte and PEC.
// Depends on smb_pkg.
module smb_engine import smb_pkg::*; #(
   parameter int unsigned HOLD_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  smb_cmd_type          cmd,
   input  logic [HOLD_BITS-1:0] hold_long,
   input  logic [HOLD_BITS-1:0] hold_short,
   output smb_result_type       result
);

   logic                 scl_lvl_ff,     scl_lvl_in;
   logic                 sda_lvl_ff,     sda_lvl_in;
   smb_mode_type         mode_ff,        mode_in;
   logic                 busy_ff,        busy_in;
   logic [4:0]           phase_ff,       phase_in;
   logic [HOLD_BITS-1:0] hold_ff,        hold_in;
   logic [7:0]           shift_ff,       shift_in;
   logic [7:0]           crc_ff,         crc_in;
   logic                 nack_ff,        nack_in;
   logic                 nack_choice_ff, nack_choice_in;
   logic [7:0]           last_read_ff,   last_read_in;
   logic                 done_in;

   logic [HOLD_BITS-1:0] hold_long_eff;
   logic [HOLD_BITS-1:0] hold_short_eff;
   logic [HOLD_BITS-1:0] hold_dec;
   logic [4:0]           phase_next;
   logic [4:0]           load_index;
   logic                 load_phase;
   logic                 cmd_end;
   smb_drive_type        drive;

   assign hold_long_eff  = (hold_long  == '0) ? HOLD_BITS'(1) : hold_long;
   assign hold_short_eff = (hold_short == '0) ? HOLD_BITS'(1) : hold_short;
   assign hold_dec       = hold_ff - HOLD_BITS'(1);
   assign phase_next     = phase_ff + 5'd1;

   always_comb begin
      scl_lvl_in     = scl_lvl_ff;
      sda_lvl_in     = sda_lvl_ff;
      mode_in        = mode_ff;
      busy_in        = busy_ff;
      phase_in       = phase_ff;
      hold_in        = hold_ff;
      shift_in       = shift_ff;
      crc_in         = crc_ff;
      nack_in        = nack_ff;
      nack_choice_in = nack_choice_ff;
      last_read_in   = last_read_ff;
      done_in        = 1'b0;
      load_phase     = 1'b0;
      load_index     = 5'd0;
      cmd_end        = 1'b0;
      if (!busy_ff) begin
         if (cmd.cmd_valid) begin
            mode_in  = smb_mode_type'(cmd.mode);
            busy_in  = 1'b1;
            phase_in = 5'd0;
            case (smb_mode_type'(cmd.mode))
               MODE_START: crc_in = 8'h00;
               MODE_WRITE: shift_in = cmd.write_data;
               MODE_READ: begin
                  shift_in       = 8'h00;
                  nack_choice_in = cmd.send_nack;
               end
               default: ;
            endcase
            load_phase = 1'b1;
         end
      end else begin
         hold_in = hold_dec;
         if (hold_dec == '0) begin
            if (mode_ff == MODE_WRITE && phase_ff == WR_ACK_SAMPLE) begin
               nack_in = cmd.sda_in;
               cmd_end = cmd.sda_in;
            end
            if (mode_ff == MODE_READ && phase_ff < RD_BIT_PHASES && phase_ff[0]) begin
               shift_in = {shift_ff[6:0], cmd.sda_in};
            end
            if (!cmd_end) begin
               phase_in = phase_next;
               if (phase_next >= phase_total(mode_ff)) begin
                  cmd_end = 1'b1;
               end else begin
                  load_phase = 1'b1;
                  load_index = phase_next;
               end
            end
            if (cmd_end) begin
               if (mode_ff == MODE_WRITE) begin
                  crc_in = crc_add(crc_ff, shift_in);
               end else if (mode_ff == MODE_READ) begin
                  last_read_in = shift_in;
                  crc_in       = crc_add(crc_ff, shift_in);
               end
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
      drive = phase_drive(mode_in, load_index, shift_in, nack_choice_in,
                          scl_lvl_ff, sda_lvl_ff);
      if (load_phase) begin
         scl_lvl_in = drive.scl;
         sda_lvl_in = drive.sda;
         hold_in    = drive.lng ? hold_long_eff : hold_short_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scl_lvl_ff     <= 1'b1;
         sda_lvl_ff     <= 1'b1;
         mode_ff        <= MODE_START;
         busy_ff        <= 1'b0;
         phase_ff       <= 5'd0;
         hold_ff        <= '0;
         shift_ff       <= 8'h00;
         crc_ff         <= 8'h00;
         nack_ff        <= 1'b0;
         nack_choice_ff <= 1'b0;
         last_read_ff   <= 8'h00;
      end else if (step) begin
         scl_lvl_ff     <= scl_lvl_in;
         sda_lvl_ff     <= sda_lvl_in;
         mode_ff        <= mode_in;
         busy_ff        <= busy_in;
         phase_ff       <= phase_in;
         hold_ff        <= hold_in;
         shift_ff       <= shift_in;
         crc_ff         <= crc_in;
         nack_ff        <= nack_in;
         nack_choice_ff <= nack_choice_in;
         last_read_ff   <= last_read_in;
      end
   end

   assign result.scl_out   = scl_lvl_in;
   assign result.sda_out   = sda_lvl_in;
   assign result.busy_res  = busy_in;
   assign result.done_res  = done_in;
   assign result.nack_seen = nack_in;
   assign result.read_data = last_read_in;
   assign result.pec       = crc_in;

   a_busy_hold_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> hold_ff != '0)
      else $error("hold timer empty while a command runs");

   a_phase_in_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> phase_ff < phase_total(mode_ff))
      else $error("phase index past end of sequence");

   a_busy_from_command: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> $past(step && cmd.cmd_valid))
      else $error("command started without an offered command");

   a_finish_pulses_done: assert property (@(posedge clock) disable iff (reset)
      step && busy_ff && !busy_in |-> done_in)
      else $error("command ended without done");

endmodule

// File: rtl/core/smbus_master_with_pec.sv
// SMBus byte-level master with CRC-8 PEC. Each request beat is one bus tick and
// yields exactly one response beat carrying the line levels and status after that
// tick. A beat is taken every clock cycle unless the response side stalls; its
// response appears in the output register on the next cycle, and a new beat is
// taken while that response is being read out, so throughput is one tick per
// clock. Start, write, read and stop phases are held for hold_long or hold_short
// ticks (register 0 and 1). Depends on smb_pkg, smb_req_if, smb_rsp_if, smb_engine.
module smbus_master_with_pec import smb_pkg::*; #(
   parameter int unsigned HOLD_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   smb_req_if.sink              req_chan,
   smb_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [CSR_WIDTH-1:0] csr_wdata
);

   logic [CSR_WIDTH-1:0] hold_long_ff;
   logic [CSR_WIDTH-1:0] hold_short_ff;
   logic                 rsp_valid_ff;
   smb_result_type       rsp_data_ff;
   smb_result_type       eng_result;
   smb_cmd_type          eng_cmd;
   logic                 req_accept;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign eng_cmd.cmd_valid  = req_chan.cmd_valid;
   assign eng_cmd.mode       = req_chan.mode;
   assign eng_cmd.write_data = req_chan.write_data;
   assign eng_cmd.send_nack  = req_chan.send_nack;
   assign eng_cmd.sda_in     = req_chan.sda_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_long_ff  <= CSR_WIDTH'(2);
         hold_short_ff <= CSR_WIDTH'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HOLD_LONG:  hold_long_ff  <= csr_wdata;
            CSR_HOLD_SHORT: hold_short_ff <= csr_wdata;
         endcase
      end
   end

   smb_engine #(
      .HOLD_BITS (HOLD_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .step       (req_accept),
      .cmd        (eng_cmd),
      .hold_long  (HOLD_BITS'(hold_long_ff)),
      .hold_short (HOLD_BITS'(hold_short_ff)),
      .result     (eng_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= eng_result;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.scl_out   = rsp_data_ff.scl_out;
   assign rsp_chan.sda_out   = rsp_data_ff.sda_out;
   assign rsp_chan.busy_res  = rsp_data_ff.busy_res;
   assign rsp_chan.done_res  = rsp_data_ff.done_res;
   assign rsp_chan.nack_seen = rsp_data_ff.nack_seen;
   assign rsp_chan.read_data = rsp_data_ff.read_data;
   assign rsp_chan.pec       = rsp_data_ff.pec;

   a_accept_fills_output: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted beat produced no response");

   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.done_res |-> !rsp_data_ff.busy_res)
      else $error("done reported while still busy");

   a_stall_holds_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("response beat changed while stalled");

endmodule
